// ----- rtl/tsb64_pkg.sv -----
// Shared types, constants and the base64 character function for the
// timestamp trace base64 dump block. No dependencies.
package tsb64_pkg;

    localparam int TICK_W    = 32;
    localparam int TAG_W     = 16;
    localparam int ENTRY_W   = TICK_W + TAG_W;
    localparam int S_TDATA_W = 48;
    localparam int TEXT_W    = 64;
    localparam int CHAR_W    = 8;
    localparam int GROUP_W   = 6;
    localparam int N_CHARS   = 8;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [5:0] GRP_LOWER = 6'd26;
    localparam logic [5:0] GRP_DIGIT = 6'd52;
    localparam logic [5:0] GRP_PLUS  = 6'd62;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } tsb64_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store;
        logic flush;
        logic issue;
    } tsb64_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
        logic can_issue;
        logic rd_last;
    } tsb64_sts_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] r;
        c = 8'(v);
        if (v < GRP_LOWER) begin
            r = CH_UPPER_A + c;
        end else if (v < GRP_DIGIT) begin
            r = CH_LOWER_A + (c - 8'(GRP_LOWER));
        end else if (v < GRP_PLUS) begin
            r = CH_DIGIT_0 + (c - 8'(GRP_DIGIT));
        end else if (v == GRP_PLUS) begin
            r = CH_PLUS;
        end else begin
            r = CH_SLASH;
        end
        return r;
    endfunction

endpackage

// ----- rtl/tsb64_ctrl.sv -----
// Controller state machine: input handshake, flush sequencing.
// Depends on tsb64_pkg.
module tsb64_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              kind,
    input  tsb64_pkg::tsb64_sts_t sts,
    output tsb64_pkg::tsb64_cmd_t cmd
);
    import tsb64_pkg::*;

    tsb64_state_t state_reg, state_next;
    logic         accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.store = accept && (kind == KIND_STORE);
        cmd.flush = accept && (kind == KIND_FLUSH);
        cmd.issue = (state_reg == ST_FLUSH) && sts.can_issue;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.flush && !sts.cnt_zero) state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                // leave once the final entry's read goes out
                if (cmd.issue && sts.rd_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/tsb64_dp.sv -----
// Datapath: entry memory, fill count, overflow flag, read stage,
// base64 encoder and output register. Depends on tsb64_pkg.
module tsb64_dp #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tsb64_pkg::S_TDATA_W-1:0] s_tdata,
    input  tsb64_pkg::tsb64_cmd_t         cmd,
    output tsb64_pkg::tsb64_sts_t         sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsb64_pkg::TEXT_W-1:0]  m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import tsb64_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [ENTRY_W-1:0] mem [BUFFER_DEPTH];

    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      rd_idx_reg, last_idx_reg;
    logic               flush_ovf_reg;
    logic               full;
    logic [ENTRY_W-1:0] wr_entry;

    logic               s1_vld_reg;
    logic [ENTRY_W-1:0] s1_data_reg;
    logic               s1_last_reg, s1_ovf_reg;

    logic               m_vld_reg;
    logic [TEXT_W-1:0]  m_data_reg;
    logic               m_last_reg, m_ovf_reg;

    logic               out_load;
    logic [TEXT_W-1:0]  text;

    assign full     = (count_reg == CW'(BUFFER_DEPTH));
    // ticks in the upper bits, tag below
    assign wr_entry = {s_tdata[TICK_W-1:0], s_tdata[TICK_W +: TAG_W]};

    assign out_load = s1_vld_reg && (!m_vld_reg || m_tready);

    always_comb begin
        sts.cnt_zero  = (count_reg == '0);
        sts.can_issue = !s1_vld_reg || out_load;
        sts.rd_last   = (rd_idx_reg == last_idx_reg);
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.flush) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end else if (cmd.store) begin
            if (full) ovf_next = 1'b1;
            else      count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // memory: one write port (store), one registered read port (flush)
    always_ff @(posedge aclk) begin
        if (cmd.store && !full) mem[count_reg[AW-1:0]] <= wr_entry;
        if (cmd.issue)          s1_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.flush) begin
            rd_idx_reg    <= '0;
            last_idx_reg  <= AW'(count_reg - 1'b1);
            flush_ovf_reg <= ovf_reg;
        end else if (cmd.issue) begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
        if (cmd.issue) begin
            s1_last_reg <= (rd_idx_reg == last_idx_reg);
            s1_ovf_reg  <= flush_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            if (cmd.issue)     s1_vld_reg <= 1'b1;
            else if (out_load) s1_vld_reg <= 1'b0;
            if (out_load)      m_vld_reg  <= 1'b1;
            else if (m_tready) m_vld_reg  <= 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < N_CHARS; k++) begin
            text[TEXT_W-1-CHAR_W*k -: CHAR_W] =
                b64_char(s1_data_reg[ENTRY_W-1-GROUP_W*k -: GROUP_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= text;
            m_last_reg <= s1_last_reg;
            m_ovf_reg  <= s1_ovf_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

endmodule

// ----- rtl/timestamp_trace_base64_dump.sv -----
// Timestamp trace buffer with base64 dump: each store item appends one entry
// (or sets overflow if full); a flush emits one transaction per entry at one
// per cycle unless m_tready stalls. The first result passes the memory read
// register, then the output register; the read port pauses while it stalls.
// While a flush reads out, s_tready is low; it returns once the last read goes.
// Reset (aresetn low, synchronous) empties the buffer and clears overflow.
module timestamp_trace_base64_dump #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] tick_count, [47:32] tag
    input  logic        s_tuser,   // [0] kind: 0 store, 1 flush
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] line_text, first char in [63:56]
    output logic        m_tlast,   // last entry of a flush
    output logic        m_tuser    // [0] overflowed
);
    import tsb64_pkg::*;

    tsb64_cmd_t cmd;
    tsb64_sts_t sts;

    // controller: accept transactions, step the flush read sequence
    tsb64_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: hold entries, encode on readout, drive the result channel
    tsb64_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/tsb64_checker.sv -----
// Port-level checks for timestamp_trace_base64_dump, attached by bind.
// Depends on tsb64_pkg for the character codes.
module tsb64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
    import tsb64_pkg::*;

    function automatic logic is_b64(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_A + 8'd25)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_A + 8'd25)) ||
               ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_0 + 8'd9)) ||
               (c == CH_PLUS) || (c == CH_SLASH);
    endfunction

    logic first_ok, last_ok;
    assign first_ok = is_b64(m_tdata[63:56]);
    assign last_ok  = is_b64(m_tdata[7:0]);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    a_first_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> first_ok)
        else $error("first character outside base64 alphabet");

    a_last_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> last_ok)
        else $error("last character outside base64 alphabet");

endmodule

bind timestamp_trace_base64_dump tsb64_checker u_tsb64_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
